FILE: rtl/pstr_pkg.sv
package pstr_pkg;

  // Opcodes of the request channel
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_MON_EN  = 2'd0;
  localparam logic [1:0] REG_WINDOW  = 2'd1;
  localparam logic [1:0] REG_PEAK_EN = 2'd2;

  // Peak RSSI value that means no receive packet seen yet
  localparam logic signed [15:0] RSSI_NONE = 16'sh8000;

  // One slot of the ring as stored in the slot memory
  typedef struct packed {
    logic [31:0] second;
    logic [31:0] rx_packets;
    logic [31:0] tx_packets;
    logic [31:0] rx_octets;
    logic [31:0] tx_octets;
    logic [31:0] rssi_acc;
  } slot_t;

endpackage

FILE: rtl/pstr_idx.sv
// Slot index unit: value modulo SLOT_COUNT, result held until the next start
module pstr_idx import pstr_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [31:0]                   value_i,
  output logic                          done_o,
  output logic [$clog2(SLOT_COUNT)-1:0] idx_o
);

  localparam int IDX_W = $clog2(SLOT_COUNT);

  if ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0) begin : g_pow2
    // Power of two: the index is the low bits
    logic             done_q;
    logic [IDX_W-1:0] idx_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        idx_q <= value_i[IDX_W-1:0];
      end
    end

    assign done_o = done_q;
    assign idx_o  = idx_q;
  end else begin : g_serial
    // Other counts: remainder built eight bits a cycle
    localparam logic [IDX_W:0] MOD = (IDX_W + 1)'(SLOT_COUNT);

    logic             busy_q;
    logic             done_q;
    logic [1:0]       cnt_q;
    logic [31:0]      val_q;
    logic [IDX_W-1:0] rem_q;
    logic [IDX_W-1:0] rem_d;

    always_comb begin
      logic [IDX_W:0] t;
      rem_d = rem_q;
      for (int k = 0; k < 8; k++) begin
        t = {rem_d, val_q[31-k]};
        if (t >= MOD) begin
          t = t - MOD;
        end
        rem_d = t[IDX_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= 2'd0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= 2'd0;
        end else if (busy_q) begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        val_q <= value_i;
        rem_q <= '0;
      end else if (busy_q) begin
        val_q <= {val_q[23:0], 8'd0};
        rem_q <= rem_d;
      end
    end

    assign done_o = done_q;
    assign idx_o  = rem_q;
  end

endmodule

FILE: rtl/pstr_div.sv
// Average unit: signed sum over unsigned count, one quotient bit a cycle,
// truncated toward zero and saturated to 16 bits
module pstr_div import pstr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        dividend_i,
  input  logic [31:0]        divisor_i,
  output logic               done_o,
  output logic signed [15:0] quotient_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic        neg_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] dvs_q;
  logic [32:0] trial;
  logic        ge;
  logic [32:0] diff;

  // Restoring step
  assign trial = {rem_q, quo_q[31]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[31];
      quo_q <= dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
      rem_q <= 32'd0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  // Sign and saturation on the held magnitude
  always_comb begin
    if (neg_q) begin
      if (quo_q > 32'd32768) begin
        quotient_o = 16'sh8000;
      end else begin
        quotient_o = signed'(~quo_q[15:0] + 16'd1);
      end
    end else begin
      if (quo_q > 32'd32767) begin
        quotient_o = 16'sh7fff;
      end else begin
        quotient_o = signed'(quo_q[15:0]);
      end
    end
  end

  assign done_o = done_q;

endmodule

FILE: rtl/per_second_traffic_stats_ring_core.sv
// Per-second traffic statistics ring. Requests carry an opcode: an update
// counts one packet into the slot of its second, a read returns one history
// row per past second (newest first, up to window_seconds and at most
// SLOT_COUNT-1 rows) and then the peak row when that row is enabled, and a
// peak reset clears the peaks. All slots live in one memory with a
// registered read; each update is a read, modify and write back of one slot.
// An update passes the index register, the memory read and the write back,
// during which the next request is taken; when SLOT_COUNT is not a power of
// two the slot index unit first builds the modulo serially and flags it done.
// A read computes the index, then for each history row reads the slot and,
// when the second has receive packets, runs the average divider before the
// row waits for the output. The peak reset and an ignored update leave the
// block idle. Slots read as zero until first written, through one valid bit
// per slot, so no clearing pass follows reset.
module per_second_traffic_stats_ring_core import pstr_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [31:0]        now_seconds_i,
  input  logic [31:0]        byte_count_i,
  input  logic signed [15:0] rssi_i,
  input  logic               is_receive_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               row_kind_o,
  output logic [2:0]         age_seconds_o,
  output logic [31:0]        rx_packets_o,
  output logic [31:0]        tx_packets_o,
  output logic [31:0]        rx_octets_o,
  output logic [31:0]        tx_octets_o,
  output logic signed [15:0] rssi_value_o,
  output logic               rssi_valid_o,
  output logic               last_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IDX_W    = $clog2(SLOT_COUNT);
  localparam int HIST_CAP = (SLOT_COUNT - 1 < 7) ? SLOT_COUNT - 1 : 7;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [2:0]       HIST_MAX = 3'(HIST_CAP);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_IDX     = 8'b0000_0010,
    S_UPD     = 8'b0000_0100,
    S_RD_ADDR = 8'b0000_1000,
    S_RD_DATA = 8'b0001_0000,
    S_DIV     = 8'b0010_0000,
    S_ROW     = 8'b0100_0000,
    S_PEAK    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic       mon_en_q;
  logic [2:0] win_q;
  logic       peak_en_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_en_q  <= 1'b1;
      win_q     <= 3'd7;
      peak_en_q <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MON_EN:  mon_en_q  <= pwdata[0];
        REG_WINDOW:  win_q     <= pwdata[2:0];
        REG_PEAK_EN: peak_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MON_EN:  prdata = {31'd0, mon_en_q};
      REG_WINDOW:  prdata = {29'd0, win_q};
      REG_PEAK_EN: prdata = {31'd0, peak_en_q};
      default:     prdata = 32'd0;
    endcase
  end

  // Request acceptance and capture
  logic               in_acc;
  logic               needs_idx;
  logic               clr_peaks;
  logic [1:0]         op_q;
  logic [31:0]        now_q;
  logic [31:0]        bytes_q;
  logic signed [15:0] rssi_q;
  logic               rx_q;

  assign in_ready_o = (state_q == S_IDLE) || (state_q == S_UPD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign needs_idx  = ((opcode_i == OP_UPDATE) && mon_en_q) || (opcode_i == OP_READ);
  assign clr_peaks  = in_acc && (opcode_i == OP_CLEAR);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= opcode_i;
      now_q   <= now_seconds_i;
      bytes_q <= byte_count_i;
      rssi_q  <= rssi_i;
      rx_q    <= is_receive_i;
    end
  end

  // Slot index unit
  logic             idx_done;
  logic [IDX_W-1:0] idx;

  pstr_idx #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_idx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_acc && needs_idx),
    .value_i(now_seconds_i),
    .done_o (idx_done),
    .idx_o  (idx)
  );

  // Slot memory with per-slot valid bits
  slot_t            mem [SLOT_COUNT];
  slot_t            rd_q;
  logic             rd_vld_q;
  logic [SLOT_COUNT-1:0] slot_vld_q;
  logic             mem_re;
  logic             mem_we;
  logic [IDX_W-1:0] rd_addr;
  slot_t            wr_ent;
  slot_t            ent;

  logic [IDX_W-1:0] walk_idx_q;

  assign mem_re  = ((state_q == S_IDX) && idx_done) || (state_q == S_RD_ADDR);
  assign rd_addr = (state_q == S_IDX) ? idx : walk_idx_q;
  assign mem_we  = (state_q == S_UPD);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx] <= wr_ent;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (mem_we) begin
        slot_vld_q[idx] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= slot_vld_q[rd_addr];
      end
    end
  end

  assign ent = rd_vld_q ? rd_q : '0;

  // Update: accumulate on a current hit, else restart the slot
  logic [IDX_W-1:0] cur_slot_q;
  logic             upd_hit;
  logic [31:0]      rssi_ext;

  assign upd_hit  = (cur_slot_q == idx) && (ent.second == now_q);
  assign rssi_ext = {{16{rssi_q[15]}}, rssi_q};

  always_comb begin
    wr_ent = ent;
    if (upd_hit) begin
      if (rx_q) begin
        wr_ent.rx_packets = ent.rx_packets + 32'd1;
        wr_ent.rx_octets  = ent.rx_octets + bytes_q;
        wr_ent.rssi_acc   = ent.rssi_acc + rssi_ext;
      end else begin
        wr_ent.tx_packets = ent.tx_packets + 32'd1;
        wr_ent.tx_octets  = ent.tx_octets + bytes_q;
      end
    end else begin
      wr_ent.second     = now_q;
      wr_ent.rx_packets = rx_q ? 32'd1 : 32'd0;
      wr_ent.rx_octets  = rx_q ? bytes_q : 32'd0;
      wr_ent.rssi_acc   = rx_q ? rssi_ext : 32'd0;
      wr_ent.tx_packets = rx_q ? 32'd0 : 32'd1;
      wr_ent.tx_octets  = rx_q ? 32'd0 : bytes_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_slot_q <= '0;
    end else if (mem_we && !upd_hit) begin
      cur_slot_q <= idx;
    end
  end

  // Peaks; a peak reset taken in the write-back cycle wins
  logic [31:0]        pk_rxp_q;
  logic [31:0]        pk_txp_q;
  logic [31:0]        pk_rxb_q;
  logic [31:0]        pk_txb_q;
  logic signed [15:0] pk_rssi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_rxp_q  <= 32'd0;
      pk_txp_q  <= 32'd0;
      pk_rxb_q  <= 32'd0;
      pk_txb_q  <= 32'd0;
      pk_rssi_q <= RSSI_NONE;
    end else if (clr_peaks) begin
      pk_rxp_q  <= 32'd0;
      pk_txp_q  <= 32'd0;
      pk_rxb_q  <= 32'd0;
      pk_txb_q  <= 32'd0;
      pk_rssi_q <= RSSI_NONE;
    end else if (mem_we) begin
      if (rx_q) begin
        if (pk_rxp_q < wr_ent.rx_packets) pk_rxp_q <= wr_ent.rx_packets;
        if (pk_rxb_q < wr_ent.rx_octets)  pk_rxb_q <= wr_ent.rx_octets;
        if (pk_rssi_q < rssi_q)           pk_rssi_q <= rssi_q;
      end else begin
        if (pk_txp_q < wr_ent.tx_packets) pk_txp_q <= wr_ent.tx_packets;
        if (pk_txb_q < wr_ent.tx_octets)  pk_txb_q <= wr_ent.tx_octets;
      end
    end
  end

  // Average divider
  logic               div_start;
  logic               div_done;
  logic signed [15:0] div_quo;

  pstr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(ent.rssi_acc),
    .divisor_i (ent.rx_packets),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Read walk registers
  logic [2:0]  age_q;
  logic [31:0] sec_q;
  logic [2:0]  left_q;
  logic [2:0]  rows;
  logic        row_hit;
  logic        row_rssi_vld;
  logic        walk_init;
  logic        walk_step;
  logic [IDX_W-1:0] walk_src;
  logic [IDX_W-1:0] walk_prev;

  assign rows         = (win_q > HIST_MAX) ? HIST_MAX : win_q;
  assign row_hit      = (ent.second == sec_q);
  assign row_rssi_vld = row_hit && (ent.rx_packets != 32'd0);
  assign div_start    = (state_q == S_RD_DATA) && row_rssi_vld;
  assign walk_src     = (state_q == S_IDX) ? idx : walk_idx_q;
  assign walk_prev    = (walk_src == '0) ? LAST_IDX : walk_src - IDX_W'(1);

  // Output register
  logic               out_valid_q;
  logic               out_free;
  logic               out_load;
  logic               out_peak;

  assign out_free = !out_valid_q || out_ready_i;

  // Control
  always_comb begin
    state_d   = state_q;
    walk_init = 1'b0;
    walk_step = 1'b0;
    out_load  = 1'b0;
    out_peak  = 1'b0;
    case (state_q)
      S_IDLE, S_UPD: begin
        if (in_acc && needs_idx) begin
          state_d = S_IDX;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_IDX: begin
        if (idx_done) begin
          if (op_q == OP_UPDATE) begin
            state_d = S_UPD;
          end else begin
            walk_init = 1'b1;
            if (rows != 3'd0) begin
              state_d = S_RD_ADDR;
            end else if (peak_en_q) begin
              state_d = S_PEAK;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      S_RD_ADDR: state_d = S_RD_DATA;
      S_RD_DATA: state_d = row_rssi_vld ? S_DIV : S_ROW;
      S_DIV: begin
        if (div_done) begin
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        if (out_free) begin
          out_load  = 1'b1;
          walk_step = 1'b1;
          if (left_q != 3'd1) begin
            state_d = S_RD_ADDR;
          end else if (peak_en_q) begin
            state_d = S_PEAK;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_PEAK: begin
        if (out_free) begin
          out_load = 1'b1;
          out_peak = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk back one slot and one second per history row
  always_ff @(posedge clk_i) begin
    if (walk_init) begin
      walk_idx_q <= walk_prev;
      age_q      <= 3'd1;
      sec_q      <= now_q - 32'd1;
      left_q     <= rows;
    end else if (walk_step) begin
      walk_idx_q <= walk_prev;
      age_q      <= age_q + 3'd1;
      sec_q      <= sec_q - 32'd1;
      left_q     <= left_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (out_peak) begin
        row_kind_o    <= 1'b1;
        age_seconds_o <= 3'd0;
        rx_packets_o  <= pk_rxp_q;
        tx_packets_o  <= pk_txp_q;
        rx_octets_o   <= pk_rxb_q;
        tx_octets_o   <= pk_txb_q;
        rssi_valid_o  <= (pk_rssi_q != RSSI_NONE);
        rssi_value_o  <= (pk_rssi_q != RSSI_NONE) ? pk_rssi_q : 16'sd0;
        last_o        <= 1'b1;
      end else begin
        row_kind_o    <= 1'b0;
        age_seconds_o <= age_q;
        rx_packets_o  <= row_hit ? ent.rx_packets : 32'd0;
        tx_packets_o  <= row_hit ? ent.tx_packets : 32'd0;
        rx_octets_o   <= row_hit ? ent.rx_octets : 32'd0;
        tx_octets_o   <= row_hit ? ent.tx_octets : 32'd0;
        rssi_valid_o  <= row_rssi_vld;
        rssi_value_o  <= row_rssi_vld ? div_quo : 16'sd0;
        last_o        <= (left_q == 3'd1) && !peak_en_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/pstr_chk.sv
// Port-level checks of the statistics ring
module pstr_chk import pstr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               row_kind_o,
  input logic [2:0]         age_seconds_o,
  input logic [31:0]        rx_packets_o,
  input logic [31:0]        tx_packets_o,
  input logic signed [15:0] rssi_value_o,
  input logic               rssi_valid_o,
  input logic               last_o
);

  // A stalled result row holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rx_packets_o)
      && $stable(tx_packets_o) && $stable(row_kind_o) && $stable(last_o))
    else $error("result row changed while stalled");

  // The peak row always closes a read and has age zero
  a_peak_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_kind_o |-> (age_seconds_o == 3'd0) && last_o)
    else $error("peak row with age or not last");

  // History rows are at least one second old
  a_hist_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !row_kind_o |-> age_seconds_o != 3'd0)
    else $error("history row of age zero");

  // Without a valid RSSI the value reads zero
  a_rssi_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rssi_valid_o |-> rssi_value_o == 16'sd0)
    else $error("rssi value not zero while invalid");

endmodule

bind per_second_traffic_stats_ring_core pstr_chk u_pstr_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .row_kind_o   (row_kind_o),
  .age_seconds_o(age_seconds_o),
  .rx_packets_o (rx_packets_o),
  .tx_packets_o (tx_packets_o),
  .rssi_value_o (rssi_value_o),
  .rssi_valid_o (rssi_valid_o),
  .last_o       (last_o)
);
